// File: src/ellr_pkg.sv
// Shared types and constants for the ellipse rasterizer.
// No dependencies; imported by every other module of the block.
`default_nettype none

package ellr_pkg;

    // canvas edge: input coordinates above CANVAS_SIZE-1 are clamped
    localparam int CANVAS_SIZE = 4096;

    localparam int COORD_W = 12;            // input coordinate
    localparam int POS_W   = 15;            // signed walk position
    localparam int DIM_W   = 14;            // box width / height
    localparam int TERM_W  = 48;            // error walk terms
    localparam int ALU_W   = TERM_W + 2;    // room for 2*error and a compare

    localparam int MUL_A_W = DIM_W + 1;
    localparam int MUL_B_W = 2 * DIM_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;

    localparam logic [COORD_W:0] COORD_MAX =
        (CANVAS_SIZE - 1 > 2**COORD_W - 1) ? (COORD_W+1)'(2**COORD_W - 1)
                                           : (COORD_W+1)'(CANVAS_SIZE - 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WALK,
        PH_TAIL
    } phase_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_BOX,
        SQ_DIM,
        SQ_MUL_W,
        SQ_MUL_H,
        SQ_MUL_X,
        SQ_ERR_A,
        SQ_ERR_B,
        SQ_CMP_Y,
        SQ_CMP_X,
        SQ_ADD_Y,
        SQ_ERR_Y,
        SQ_CMP_E,
        SQ_ADD_X,
        SQ_ERR_X,
        SQ_FIN
    } seq_t;

    // decoded input request
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic               centered;
        logic               keep_square;
    } cmd_t;

    // one point set
    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] lower;
        logic signed [POS_W-1:0] upper;
        logic                    last;
    } res_t;

endpackage

`default_nettype wire

// File: src/ellr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ellr_pkg for operand widths.
`default_nettype none

module ellr_mul (
    input  logic                                 aclk,
    input  logic signed [ellr_pkg::MUL_A_W-1:0]  a,
    input  logic signed [ellr_pkg::MUL_B_W-1:0]  b,
    output logic signed [ellr_pkg::MUL_P_W-1:0]  p
);
    import ellr_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: src/ellr_alu.sv
// Shared wide adder / comparator for the error walk.
// Depends on ellr_pkg for the datapath width.
`default_nettype none

module ellr_alu (
    input  logic signed [ellr_pkg::ALU_W-1:0] a,
    input  logic signed [ellr_pkg::ALU_W-1:0] b,
    input  logic                              sub,
    output logic signed [ellr_pkg::ALU_W-1:0] sum,
    output logic                              neg,
    output logic                              zero
);
    import ellr_pkg::*;

    // a + b, or a - b as a + ~b + 1
    assign sum  = a + (sub ? ~b : b) + ALU_W'(sub);
    assign neg  = sum[ALU_W-1];
    assign zero = (sum == '0);

endmodule

`default_nettype wire

// File: src/ellr_core.sv
// Sequencer and walk registers of the ellipse rasterizer.
// Depends on ellr_pkg, ellr_mul and ellr_alu.
`default_nettype none

module ellr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  ellr_pkg::cmd_t      cmd,
    output logic                idle,
    input  logic                out_free,
    output logic                res_valid,
    output ellr_pkg::res_t      res
);
    import ellr_pkg::*;

    localparam logic signed [MUL_A_W-1:0] ONE_A = MUL_A_W'(1);
    localparam logic signed [POS_W-1:0]   ONE_P = POS_W'(1);

    function automatic logic signed [POS_W-1:0] mag(input logic signed [POS_W-1:0] v);
        mag = v[POS_W-1] ? -v : v;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        sat_coord = ({1'b0, v} > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : v;
    endfunction

    function automatic logic signed [ALU_W-1:0] ext(input logic signed [TERM_W-1:0] t);
        ext = ALU_W'(t);
    endfunction

    seq_t   seq_reg, seq_next;
    phase_t phase_reg, phase_next;

    // latched start request
    logic [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic               ctr_reg, sq_reg;

    // bounding box and walk position
    logic signed [POS_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [POS_W-1:0] left_reg, right_reg, lower_reg, upper_reg;
    logic [DIM_W-1:0]        w_reg, hbox_reg;
    logic                    hodd_reg;

    // error walk terms
    logic signed [TERM_W-1:0] err_reg, xstep_reg, ystep_reg, winc_reg, hinc_reg;
    logic signed [TERM_W-1:0] w2_reg, h2_reg;

    // per-step decisions
    logic c1_reg, c2_reg, xhit_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [TERM_W-1:0]  p_ext;
    logic signed [ALU_W-1:0]   alu_a, alu_b, alu_sum, e2;
    logic                      alu_sub, alu_neg, alu_zero;

    ellr_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ellr_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .neg  (alu_neg),
        .zero (alu_zero)
    );

    assign p_ext = TERM_W'(mul_p);
    assign e2    = ext(err_reg) <<< 1;
    assign idle  = (seq_reg == SQ_IDLE);

    // box from the latched points
    logic signed [POS_W-1:0] axs, ays, bxs, bys, rx, ry, rmax, rxs, rys, dy;
    logic signed [POS_W-1:0] bx0, by0, bx1, by1;

    always_comb begin
        axs  = $signed({{(POS_W-COORD_W){1'b0}}, ax_reg});
        ays  = $signed({{(POS_W-COORD_W){1'b0}}, ay_reg});
        bxs  = $signed({{(POS_W-COORD_W){1'b0}}, bx_reg});
        bys  = $signed({{(POS_W-COORD_W){1'b0}}, by_reg});
        rx   = mag(bxs - axs);
        ry   = mag(bys - ays);
        rmax = (rx > ry) ? rx : ry;
        rxs  = sq_reg ? rmax : rx;
        rys  = sq_reg ? rmax : ry;
        dy   = bys - ays;
        if (ctr_reg) begin
            bx0 = axs - rxs;
            by0 = ays - rys;
            bx1 = axs + rxs;
            by1 = ays + rys;
        end else begin
            bx0 = axs;
            by0 = ays;
            bx1 = bxs;
            // square: keep the drawn y direction, use the x distance
            if (sq_reg) begin
                by1 = dy[POS_W-1] ? ays - rx : ays + rx;
            end else begin
                by1 = bys;
            end
        end
    end

    // size and start position of the walk
    logic signed [POS_W-1:0] dx, wabs, habs, ymin, half_up, half_dn;

    always_comb begin
        dx      = x1_reg - x0_reg;
        wabs    = mag(dx);
        habs    = mag(y1_reg - y0_reg);
        ymin    = (y0_reg > y1_reg) ? y1_reg : y0_reg;
        half_up = (habs + ONE_P) >>> 1;
        half_dn = habs >>> 1;
    end

    // end-of-step position update
    logic signed [POS_W-1:0] lo_n, up_n, l_n, r_n;
    logic signed [POS_W:0]   span, hcmp;
    logic                    ydo;
    logic signed [POS_W-1:0] fin_left, fin_right;
    logic                    fin_last;

    always_comb begin
        ydo       = (phase_reg == PH_TAIL) || c1_reg;
        lo_n      = lower_reg + POS_W'(ydo);
        up_n      = upper_reg - POS_W'(ydo);
        l_n       = left_reg + POS_W'(xhit_reg);
        r_n       = right_reg - POS_W'(xhit_reg);
        span      = (POS_W+1)'(lo_n) - (POS_W+1)'(up_n);
        hcmp      = $signed({2'b00, hbox_reg});
        fin_left  = l_n;
        fin_right = r_n;
        fin_last  = 1'b0;
        phase_next = phase_reg;
        if (phase_reg == PH_TAIL) begin
            if (span >= hcmp) begin
                phase_next = PH_IDLE;
                fin_last   = 1'b1;
            end
        end else if (l_n > r_n) begin
            // x pair crossed: a crossing x step is undone
            fin_left  = left_reg;
            fin_right = right_reg;
            if (span < hcmp) begin
                phase_next = PH_TAIL;
            end else begin
                phase_next = PH_IDLE;
                fin_last   = 1'b1;
            end
        end
    end

    // shared unit operands
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (seq_reg)
            SQ_MUL_W: begin
                mul_a = $signed({1'b0, w_reg});
                mul_b = $signed(MUL_B_W'(w_reg));
            end
            SQ_MUL_H: begin
                mul_a = $signed({1'b0, hbox_reg});
                mul_b = $signed(MUL_B_W'(hbox_reg));
            end
            SQ_MUL_X: begin
                mul_a = ONE_A - $signed({1'b0, w_reg});
                mul_b = $signed(mul_p[MUL_B_W-1:0]);
            end
            SQ_ERR_A: begin
                alu_a = ext(p_ext <<< 2);
                alu_b = hodd_reg ? ext(w2_reg) : '0;
            end
            SQ_ERR_B: begin
                alu_a = ext(err_reg);
                alu_b = ext(ystep_reg);
            end
            SQ_CMP_Y: begin
                alu_a   = ext(ystep_reg);
                alu_b   = e2;
                alu_sub = 1'b1;
            end
            SQ_CMP_X: begin
                alu_a   = e2;
                alu_b   = ext(xstep_reg);
                alu_sub = 1'b1;
            end
            SQ_ADD_Y: begin
                alu_a = ext(ystep_reg);
                alu_b = ext(hinc_reg);
            end
            SQ_ERR_Y: begin
                alu_a = ext(err_reg);
                alu_b = ext(ystep_reg);
            end
            SQ_CMP_E: begin
                alu_a   = e2;
                alu_b   = ext(ystep_reg);
                alu_sub = 1'b1;
            end
            SQ_ADD_X: begin
                alu_a = ext(xstep_reg);
                alu_b = ext(winc_reg);
            end
            SQ_ERR_X: begin
                alu_a = ext(err_reg);
                alu_b = ext(xstep_reg);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        seq_next  = seq_reg;
        res_valid = 1'b0;
        unique case (seq_reg)
            SQ_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.op == OP_START) begin
                        seq_next = SQ_BOX;
                    end else if (phase_reg == PH_WALK) begin
                        seq_next = SQ_CMP_Y;
                    end else if (phase_reg == PH_TAIL) begin
                        seq_next = SQ_FIN;
                    end
                end
            end
            SQ_BOX:   seq_next = SQ_DIM;
            SQ_DIM:   seq_next = SQ_MUL_W;
            SQ_MUL_W: seq_next = SQ_MUL_H;
            SQ_MUL_H: seq_next = SQ_MUL_X;
            SQ_MUL_X: seq_next = SQ_ERR_A;
            SQ_ERR_A: seq_next = SQ_ERR_B;
            SQ_ERR_B: seq_next = SQ_IDLE;
            SQ_CMP_Y: seq_next = SQ_CMP_X;
            SQ_CMP_X: begin
                priority if (c1_reg) begin
                    seq_next = SQ_ADD_Y;
                end else if (!alu_neg) begin
                    seq_next = SQ_ADD_X;
                end else begin
                    seq_next = SQ_CMP_E;
                end
            end
            SQ_ADD_Y: seq_next = SQ_ERR_Y;
            SQ_ERR_Y: seq_next = c2_reg ? SQ_ADD_X : SQ_CMP_E;
            SQ_CMP_E: seq_next = (!alu_neg && !alu_zero) ? SQ_ADD_X : SQ_FIN;
            SQ_ADD_X: seq_next = SQ_ERR_X;
            SQ_ERR_X: seq_next = SQ_FIN;
            SQ_FIN: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    seq_next  = SQ_IDLE;
                end
            end
            default: seq_next = SQ_IDLE;
        endcase
    end

    // result shows the position before this step
    always_comb begin
        res.left  = left_reg;
        res.right = right_reg;
        res.lower = lower_reg;
        res.upper = upper_reg;
        res.last  = fin_last;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SQ_IDLE;
            phase_reg <= PH_IDLE;
        end else begin
            seq_reg <= seq_next;
            if (seq_reg == SQ_ERR_A) begin
                phase_reg <= PH_WALK;
            end else if (seq_reg == SQ_FIN && out_free) begin
                phase_reg <= phase_next;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (seq_reg)
            SQ_IDLE: begin
                if (cmd_valid) begin
                    ax_reg   <= sat_coord(cmd.ax);
                    ay_reg   <= sat_coord(cmd.ay);
                    bx_reg   <= sat_coord(cmd.bx);
                    by_reg   <= sat_coord(cmd.by);
                    ctr_reg  <= cmd.centered;
                    sq_reg   <= cmd.keep_square;
                    xhit_reg <= 1'b0;
                end
            end
            SQ_BOX: begin
                x0_reg <= bx0;
                y0_reg <= by0;
                x1_reg <= bx1;
                y1_reg <= by1;
            end
            SQ_DIM: begin
                w_reg     <= wabs[DIM_W-1:0];
                hbox_reg  <= habs[DIM_W-1:0];
                hodd_reg  <= habs[0];
                left_reg  <= dx[POS_W-1] ? x1_reg : x0_reg;
                right_reg <= dx[POS_W-1] ? x0_reg : x1_reg;
                lower_reg <= ymin + half_up;
                upper_reg <= ymin + half_dn;
            end
            SQ_MUL_H: w2_reg <= p_ext;
            SQ_MUL_X: h2_reg <= p_ext;
            SQ_ERR_A: begin
                xstep_reg <= p_ext <<< 2;
                ystep_reg <= hodd_reg ? (w2_reg <<< 3) : (w2_reg <<< 2);
                hinc_reg  <= w2_reg <<< 3;
                winc_reg  <= h2_reg <<< 3;
                err_reg   <= alu_sum[TERM_W-1:0];
            end
            SQ_ERR_B: err_reg <= alu_sum[TERM_W-1:0];
            SQ_CMP_Y: c1_reg  <= !alu_neg;
            SQ_CMP_X: c2_reg  <= !alu_neg;
            SQ_ADD_Y: ystep_reg <= alu_sum[TERM_W-1:0];
            SQ_ERR_Y: err_reg   <= alu_sum[TERM_W-1:0];
            SQ_ADD_X: begin
                xstep_reg <= alu_sum[TERM_W-1:0];
                xhit_reg  <= 1'b1;
            end
            SQ_ERR_X: err_reg <= alu_sum[TERM_W-1:0];
            SQ_FIN: begin
                if (out_free) begin
                    left_reg  <= fin_left;
                    right_reg <= fin_right;
                    lower_reg <= lo_n;
                    upper_reg <= up_n;
                end
            end
            default: begin
                c2_reg <= c2_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/ellipse_rasterizer.sv
// Ellipse point generator: a start request (tuser = 0) latches two points and
// produces nothing; each step request (tuser = 1) then produces one set of four
// quadrant points, the final set flagged with tlast. A step while no ellipse is
// active produces nothing. The error-walk arithmetic runs through one 50-bit adder
// and one 15x28 multiplier under a sequencer, and the block takes one request at a
// time: a start computes the box and size, then three products and the first error
// terms; a step of the error walk makes 2 compares, up to 2 add pairs and one more
// compare through the shared adder, then the update; a step of the tail walk for
// flat ellipses makes only the update. A finished point set waits in the output
// register, so a new request is taken while it is still unread.
`default_nettype none

module ellipse_rasterizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x[11:0], first_y[23:12], second_x[35:24], second_y[47:36],
    // centered[48], keep_square[49], zero fill
    input  logic [ellr_pkg::S_DATA_W-1:0]    s_tdata,
    // operation[0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // left_x[14:0], right_x[29:15], lower_y[44:30], upper_y[59:45], zero fill
    output logic [ellr_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import ellr_pkg::*;

    cmd_t cmd;
    res_t res;
    logic core_idle, res_valid, out_free;

    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic [4*POS_W-1:0]      m_data_reg;

    // unpack the request
    always_comb begin
        cmd.op          = op_t'(s_tuser[0]);
        cmd.ax          = s_tdata[COORD_W-1:0];
        cmd.ay          = s_tdata[2*COORD_W-1:COORD_W];
        cmd.bx          = s_tdata[3*COORD_W-1:2*COORD_W];
        cmd.by          = s_tdata[4*COORD_W-1:3*COORD_W];
        cmd.centered    = s_tdata[4*COORD_W];
        cmd.keep_square = s_tdata[4*COORD_W+1];
    end

    assign s_tready = core_idle;
    assign out_free = !m_valid_reg || m_tready;

    ellr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid && s_tready),
        .cmd       (cmd),
        .idle      (core_idle),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {res.upper, res.lower, res.right, res.left};
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-4*POS_W){1'b0}}, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for ellipse_rasterizer: start and step requests go in,
// point sets come out and are compared with a built-in model of the error walk.
// Depends on ellr_pkg (types, widths) and the ellipse_rasterizer RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ellr_pkg::*;

    localparam int COORD_TOP   = (1 << COORD_W) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    ellipse_rasterizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // model state of the walk
    int      pos_l, pos_r, pos_lo, pos_up, box_h;
    longint  err_acc, dx_term, dy_term, dx_inc, dy_inc;
    phase_t  walk_phase = PH_IDLE;

    res_t    expected_sets[$];
    res_t    next_set;
    int      fail_count    = 0;
    int      counted_items = 0;
    int      gap_pct       = 0;
    int      stall_pct     = 0;
    int      hold_requests = 0;
    int      hold_served   = 0;
    int      hold_left     = 0;
    int      quiet_cycles  = 0;

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_coord(logic [COORD_W-1:0] v);
        return (int'(v) > CANVAS_SIZE - 1) ? CANVAS_SIZE - 1 : int'(v);
    endfunction

    // start request: derive the box and load the error terms
    function automatic void latch_ellipse(logic [COORD_W-1:0] ax_i, ay_i, bx_i, by_i,
                                          logic ctr, logic sq);
        int     ax, ay, bx, by, rx, ry, span, x0, y0, x1, y1, w, h, hodd;
        longint w2, h2;
        ax = clamp_coord(ax_i);
        ay = clamp_coord(ay_i);
        bx = clamp_coord(bx_i);
        by = clamp_coord(by_i);
        if (ctr) begin
            rx = iabs(bx - ax);
            ry = iabs(by - ay);
            if (sq) begin
                if (ry > rx) rx = ry;
                else ry = rx;
            end
            x0 = ax - rx;
            y0 = ay - ry;
            x1 = ax + rx;
            y1 = ay + ry;
        end else begin
            x0 = ax;
            y0 = ay;
            x1 = bx;
            y1 = by;
            // square: keep the drawn direction of y
            if (sq) begin
                span = iabs(x1 - x0);
                y1 = (y1 - y0 >= 0) ? y0 + span : y0 - span;
            end
        end
        w    = iabs(x1 - x0);
        h    = iabs(y1 - y0);
        hodd = h & 1;
        w2   = longint'(w) * w;
        h2   = longint'(h) * h;
        dx_term = 4 * longint'(1 - w) * h2;
        dy_term = 4 * longint'(hodd + 1) * w2;
        err_acc = dx_term + dy_term + longint'(hodd) * w2;
        if (x0 > x1) begin
            x0 = x1;
            x1 += w;
        end
        if (y0 > y1) y0 = y1;
        y0 += (h + 1) / 2;
        y1 = y0 - hodd;
        dy_inc     = 8 * w2;
        dx_inc     = 8 * h2;
        box_h      = h;
        pos_l      = x0;
        pos_r      = x1;
        pos_lo     = y0;
        pos_up     = y1;
        walk_phase = PH_WALK;
    endfunction

    // step request: emit the current set, then advance; returns 0 when idle
    function automatic bit advance_walk(output res_t pts);
        longint twice_err;
        pts = '0;
        if (walk_phase != PH_WALK && walk_phase != PH_TAIL) return 1'b0;
        pts.left  = pos_l[POS_W-1:0];
        pts.right = pos_r[POS_W-1:0];
        pts.lower = pos_lo[POS_W-1:0];
        pts.upper = pos_up[POS_W-1:0];
        if (walk_phase == PH_WALK) begin
            twice_err = 2 * err_acc;
            if (twice_err <= dy_term) begin
                pos_lo++;
                pos_up--;
                dy_term += dy_inc;
                err_acc += dy_term;
            end
            if (twice_err >= dx_term || 2 * err_acc > dy_term) begin
                pos_l++;
                pos_r--;
                dx_term += dx_inc;
                err_acc += dx_term;
            end
            // x ends crossed: finish, or hand over to the tail for flat shapes
            if (pos_l > pos_r) begin
                if (pos_lo - pos_up < box_h) begin
                    pos_l--;
                    pos_r++;
                    walk_phase = PH_TAIL;
                end else begin
                    walk_phase = PH_IDLE;
                    pts.last   = 1'b1;
                end
            end
        end else begin
            pos_lo++;
            pos_up--;
            if (pos_lo - pos_up >= box_h) begin
                walk_phase = PH_IDLE;
                pts.last   = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // drive one request, wait for acceptance, then update the model
    task automatic send_request(op_t op, logic [COORD_W-1:0] ax, ay, bx, by,
                                logic ctr, logic sq);
        res_t pts;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, sq, ctr, by, bx, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_START) begin
            latch_ellipse(ax, ay, bx, by, ctr, sq);
            counted_items++;
        end else if (advance_walk(pts)) begin
            expected_sets.push_back(pts);
            counted_items++;
        end
    endtask

    // step with junk in the unused data fields
    task automatic send_step();
        send_request(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic finish_ellipse();
        while (walk_phase != PH_IDLE) send_step();
    endtask

    // sender idles until every predicted set has been read
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_sets.size() != 0);
    endtask

    function automatic int offset_coord(int a, int d);
        if (a - d < 0 || (a + d <= COORD_TOP && $urandom_range(1))) return a + d;
        return a - d;
    endfunction

    // one ellipse: mostly small, run to the end, sometimes cut short
    task automatic random_ellipse();
        int   sel, sx, sy, ax, ay, cut;
        logic ctr, sq;
        sel = $urandom_range(99);
        if (sel < 88) begin
            sx = $urandom_range(12);
            sy = $urandom_range(12);
        end else if (sel < 99) begin
            sx = $urandom_range(60);
            sy = $urandom_range(60);
        end else begin
            sx = $urandom_range(250);
            sy = $urandom_range(250);
        end
        ctr = 1'($urandom);
        sq  = ($urandom_range(99) < 25);
        if (ctr) begin
            sx /= 2;
            sy /= 2;
        end
        ax = $urandom_range(COORD_TOP);
        ay = $urandom_range(COORD_TOP);
        send_request(OP_START, COORD_W'(ax), COORD_W'(ay), COORD_W'(offset_coord(ax, sx)),
                     COORD_W'(offset_coord(ay, sy)), ctr, sq);
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(5);
            repeat (cut) if (walk_phase != PH_IDLE) send_step();
        end else begin
            finish_ellipse();
            if ($urandom_range(99) < 20) repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    task automatic run_random(int gap, int stall, int n_items);
        int goal;
        gap_pct   = gap;
        stall_pct = stall;
        goal      = counted_items + n_items;
        while (counted_items < goal) begin
            if ($urandom_range(99) < 5) send_step();
            else random_ellipse();
        end
    endtask

    // corners, extremes, flat and thin shapes, squares, restart and idle steps
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_step();
        send_request(OP_START, 0, 0, COORD_W'(COORD_TOP), COORD_W'(COORD_TOP), 1'b0, 1'b0);
        send_step();
        send_request(OP_START, COORD_W'(COORD_TOP), COORD_W'(COORD_TOP), 0, 0, 1'b1, 1'b1);
        send_step();
        send_request(OP_START, COORD_W'(COORD_TOP), 0, 0, COORD_W'(COORD_TOP), 1'b0, 1'b1);
        send_step();
        send_request(OP_START, 5, 5, 5, 5, 1'b0, 1'b0);
        finish_ellipse();
        send_step();
        send_request(OP_START, 100, 200, 104, 201, 1'b0, 1'b0);
        finish_ellipse();
        send_request(OP_START, 300, 300, 301, 305, 1'b0, 1'b0);
        finish_ellipse();
        send_request(OP_START, 50, 60, 46, 55, 1'b0, 1'b1);
        finish_ellipse();
        send_request(OP_START, 700, 700, 701, 703, 1'b1, 1'b1);
        finish_ellipse();
    endtask

    // the four idling mixes on both sides
    task automatic test_idle_mix();
        run_random(0, 0, 300);
        run_random(76, 0, 300);
        run_random(0, 76, 300);
        run_random(15, 15, 300);
    endtask

    // long receiver hold while requests keep coming
    task automatic test_output_hold();
        hold_requests++;
        run_random(0, 0, 80);
    endtask

    // sender stops until everything is out, then resumes
    task automatic test_drain_pause();
        run_random(15, 15, 30);
        pause_until_drained();
        run_random(0, 0, 30);
    endtask

    // receiver ready, with random stalls and an occasional long hold
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each point set with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sets.size() == 0) begin
                $error("point set with nothing predicted: tdata=%h tlast=%b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                next_set = expected_sets.pop_front();
                check_field("left_x",  next_set.left,  $signed(m_tdata[14:0]));
                check_field("right_x", next_set.right, $signed(m_tdata[29:15]));
                check_field("lower_y", next_set.lower, $signed(m_tdata[44:30]));
                check_field("upper_y", next_set.upper, $signed(m_tdata[59:45]));
                check_field("last",    int'(next_set.last), int'(m_tlast));
            end
        end
    end

    // watchdog on cycles without any accepted request or point set
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_idle_mix();
        test_output_hold();
        test_drain_pause();
        // wait for the last sets, then a quiet tail for strays
        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && expected_sets.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: ellipse_rasterizer.f
src/ellr_pkg.sv
src/ellr_mul.sv
src/ellr_alu.sv
src/ellr_core.sv
src/ellipse_rasterizer.sv
sim/tb_top.sv
